### rtl/core/dm1_dtc_frame_decoder_assert.svh
// Assertion macros shared by the DTC frame decoder modules.
`ifndef DM1_DTC_FRAME_DECODER_ASSERT_SVH
`define DM1_DTC_FRAME_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define DM1_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtc frame decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define DM1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtc frame decoder check failed");

`else

`define DM1_ASSERT_HOLDS(label, ante, cons)
`define DM1_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/dm1dtc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the fault match table of the DTC frame decoder.
package dm1dtc_pkg;

  // Frame kinds carried on the command field.
  localparam logic [1:0] CMD_SINGLE   = 2'd0;
  localparam logic [1:0] CMD_ANNOUNCE = 2'd1;
  localparam logic [1:0] CMD_DATA     = 2'd2;

  // At most this many reports leave for one completed message.
  localparam int unsigned REPORT_LIMIT = 16;

  // Depth of the report queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned TABLE_SIZE = 16;

  typedef logic [18:0] spn_t;
  typedef logic [4:0]  fmi_t;
  typedef logic [4:0]  fault_t;

  // SPNs above this value are folded down before matching.
  localparam spn_t SPN_OFFSET = 19'd19000;

  localparam spn_t MATCH_SPN [TABLE_SIZE] = '{
    19'd1, 19'd1, 19'd2, 19'd3, 19'd3, 19'd4, 19'd5, 19'd3683,
    19'd3683, 19'd6, 19'd7, 19'd7, 19'd7, 19'd8, 19'd1624, 19'd190
  };

  localparam fmi_t MATCH_FMI [TABLE_SIZE] = '{
    5'd2, 5'd12, 5'd2, 5'd2, 5'd19, 5'd2, 5'd2, 5'd2,
    5'd13, 5'd2, 5'd6, 5'd5, 5'd20, 5'd11, 5'd9, 5'd9
  };

  // One report request handed from the front part to the back part.
  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] word;
    logic [7:0]  lamp;
    logic [7:0]  flash;
    logic        last;
  } job_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic not_empty;
    logic room;
  } q_status_t;

  // Fault number of a code: first matching table row plus one, zero if none.
  function automatic fault_t lookup_fault(spn_t spn, fmi_t fmi);
    spn_t   key;
    fault_t code;
    int     k;
    key  = (spn > SPN_OFFSET) ? (spn - SPN_OFFSET) : spn;
    code = '0;
    for (k = TABLE_SIZE - 1; k >= 0; k--) begin
      if (MATCH_SPN[k] == key && MATCH_FMI[k] == fmi) begin
        code = fault_t'(k + 1);
      end
    end
    return code;
  endfunction

endpackage

### rtl/core/dm1dtc_fifo.sv
`timescale 1ns / 1ps
// Short report queue that decouples frame handling from report output.
`include "dm1_dtc_frame_decoder_assert.svh"
module dm1dtc_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_i,
  input  dm1dtc_pkg::job_t       job_i,
  input  logic                   pop_i,
  output dm1dtc_pkg::job_t       job_o,
  output dm1dtc_pkg::q_status_t  status_o
);

  localparam int unsigned PTR_W = $clog2(dm1dtc_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(dm1dtc_pkg::QUEUE_DEPTH + 1);

  dm1dtc_pkg::job_t entry_r [dm1dtc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  // A producer may start a request only with two free slots, since its
  // memory read lands in the next cycle.
  assign status_o.not_empty = (cnt_r != '0);
  assign status_o.room      = (cnt_r <= CNT_W'(dm1dtc_pkg::QUEUE_DEPTH - 2));
  assign job_o              = entry_r[rd_ptr_r];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= job_i;
    end
  end

  `DM1_ASSERT_HOLDS(a_fifo_no_overflow, push_i && cnt_r == CNT_W'(dm1dtc_pkg::QUEUE_DEPTH), pop_i)
  `DM1_ASSERT_HOLDS(a_fifo_no_underflow, pop_i, cnt_r != '0)

endmodule

### rtl/core/dm1dtc_front.sv
`timescale 1ns / 1ps
// Front part: frame acceptance, byte-serial code assembly and report sweep.
`include "dm1_dtc_frame_decoder_assert.svh"
module dm1dtc_front #(
  parameter int unsigned MAX_CODES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd_i,
  input  logic [7:0][7:0]       frame_i,
  input  logic                  room_i,
  output logic                  push_o,
  output dm1dtc_pkg::job_t      job_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CODES + 1);
  localparam int unsigned AW    = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_BYTES, ST_SWEEP} state_t;

  state_t           state_r,      state_nxt;
  logic [CNT_W-1:0] code_count_r, code_count_nxt;
  logic [1:0]       phase_r,      phase_nxt;
  logic [15:0]      seen_r,       seen_nxt;
  logic [15:0]      total_r,      total_nxt;
  logic [7:0]       lamp_r,       lamp_nxt;
  logic [7:0]       flash_r,      flash_nxt;
  logic [2:0]       pos_r,        pos_nxt;
  logic             seq1_r,       seq1_nxt;
  logic [4:0]       sweep_k_r,    sweep_k_nxt;
  logic [4:0]       n_r,          n_nxt;
  logic             rd_valid_r,   rd_valid_nxt;
  logic [3:0]       rd_idx_r,     rd_idx_nxt;
  logic             rd_last_r,    rd_last_nxt;

  logic [6:0][7:0]  frame_r;
  logic [23:0]      asm_r;
  logic [31:0]      rd_word_r;
  logic [31:0]      mem [MAX_CODES];

  logic             acc;
  logic             single_acc;
  logic [7:0]       cur_byte;
  logic             is_lamp;
  logic             is_flash;
  logic             take;
  logic             code_done;
  logic [CNT_W-1:0] count_after;
  logic [7:0]       count_wide;
  logic [15:0]      seen_inc;
  logic             hit;
  logic [4:0]       n_calc;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [31:0]      mem_wdata;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  // Handshake: held off while a frame is in work, a read is in flight or the queue lacks room.
  assign busy       = (state_r != ST_IDLE) || rd_valid_r || !room_i;
  assign acc        = start && !busy;
  assign single_acc = acc && (cmd_i == dm1dtc_pkg::CMD_SINGLE);

  // Byte classification for the data packet being walked through.
  assign cur_byte    = frame_r[pos_r];
  assign is_lamp     = seq1_r && (pos_r == 3'd0);
  assign is_flash    = seq1_r && (pos_r == 3'd1);
  assign take        = (state_r == ST_BYTES) && !is_lamp && !is_flash
                       && (code_count_r < CNT_W'(MAX_CODES));
  assign code_done   = take && (phase_r == 2'd3);
  assign count_after = code_count_r + (code_done ? CNT_W'(1) : CNT_W'(0));
  assign count_wide  = 8'(count_after);
  assign seen_inc    = seen_r + 16'd1;
  assign hit         = (seen_inc == total_r);
  assign n_calc      = (count_wide > 8'(dm1dtc_pkg::REPORT_LIMIT))
                       ? 5'(dm1dtc_pkg::REPORT_LIMIT) : count_wide[4:0];

  // Code store ports: a single frame writes entry zero whole, a data packet
  // writes an entry once the fourth byte of a code arrives.
  assign mem_we    = single_acc || code_done;
  assign mem_waddr = single_acc ? '0 : AW'(code_count_r);
  assign mem_wdata = single_acc ? {frame_i[5], frame_i[4], frame_i[3], frame_i[2]}
                                : {cur_byte, asm_r};
  assign rd_en     = (state_r == ST_SWEEP) && room_i;
  assign rd_addr   = AW'(sweep_k_r);

  // Report requests come from a single frame or from the store sweep.
  assign push_o = rd_valid_r || single_acc;
  always_comb begin
    if (single_acc) begin
      job_o.idx   = 4'd0;
      job_o.word  = {frame_i[5], frame_i[4], frame_i[3], frame_i[2]};
      job_o.lamp  = frame_i[0];
      job_o.flash = flash_r;
      job_o.last  = 1'b1;
    end else begin
      job_o.idx   = rd_idx_r;
      job_o.word  = rd_word_r;
      job_o.lamp  = lamp_r;
      job_o.flash = flash_r;
      job_o.last  = rd_last_r;
    end
  end

  // Next-state logic of the frame sequencer.
  always_comb begin
    state_nxt      = state_r;
    code_count_nxt = code_count_r;
    phase_nxt      = phase_r;
    seen_nxt       = seen_r;
    total_nxt      = total_r;
    lamp_nxt       = lamp_r;
    flash_nxt      = flash_r;
    pos_nxt        = pos_r;
    seq1_nxt       = seq1_r;
    sweep_k_nxt    = sweep_k_r;
    n_nxt          = n_r;
    rd_valid_nxt   = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    rd_last_nxt    = rd_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd_i)
            dm1dtc_pkg::CMD_SINGLE: begin
              lamp_nxt       = frame_i[0];
              code_count_nxt = CNT_W'(1);
              phase_nxt      = 2'd0;
              total_nxt      = 16'd6;
            end
            dm1dtc_pkg::CMD_ANNOUNCE: begin
              total_nxt      = {frame_i[2], frame_i[1]};
              seen_nxt       = 16'd0;
              code_count_nxt = '0;
              phase_nxt      = 2'd0;
            end
            dm1dtc_pkg::CMD_DATA: begin
              seq1_nxt  = (frame_i[0] == 8'd1);
              pos_nxt   = 3'd0;
              state_nxt = ST_BYTES;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BYTES: begin
        if (is_lamp) begin
          lamp_nxt = cur_byte;
        end
        if (is_flash) begin
          flash_nxt = cur_byte;
        end
        if (take) begin
          phase_nxt      = phase_r + 2'd1;
          code_count_nxt = count_after;
        end
        seen_nxt = seen_inc;
        if (hit) begin
          // Count reached: drop the rest of the frame and report.
          seen_nxt    = 16'd0;
          n_nxt       = n_calc;
          sweep_k_nxt = 5'd0;
          state_nxt   = (n_calc == 5'd0) ? ST_IDLE : ST_SWEEP;
        end else if (pos_r == 3'd6) begin
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
      ST_SWEEP: begin
        if (room_i) begin
          rd_valid_nxt = 1'b1;
          rd_idx_nxt   = sweep_k_r[3:0];
          rd_last_nxt  = ((sweep_k_r + 5'd1) == n_r);
          sweep_k_nxt  = sweep_k_r + 5'd1;
          if ((sweep_k_r + 5'd1) == n_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      code_count_r <= '0;
      phase_r      <= 2'd0;
      seen_r       <= 16'd0;
      total_r      <= 16'd0;
      lamp_r       <= 8'd0;
      flash_r      <= 8'd0;
      pos_r        <= 3'd0;
      seq1_r       <= 1'b0;
      sweep_k_r    <= 5'd0;
      n_r          <= 5'd0;
      rd_valid_r   <= 1'b0;
      rd_idx_r     <= 4'd0;
      rd_last_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      code_count_r <= code_count_nxt;
      phase_r      <= phase_nxt;
      seen_r       <= seen_nxt;
      total_r      <= total_nxt;
      lamp_r       <= lamp_nxt;
      flash_r      <= flash_nxt;
      pos_r        <= pos_nxt;
      seq1_r       <= seq1_nxt;
      sweep_k_r    <= sweep_k_nxt;
      n_r          <= n_nxt;
      rd_valid_r   <= rd_valid_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_last_r    <= rd_last_nxt;
    end
  end

  // Frame bytes and the partly assembled code.
  always_ff @(posedge clk) begin
    if (acc && cmd_i == dm1dtc_pkg::CMD_DATA) begin
      frame_r <= frame_i[7:1];
    end
    if (take && phase_r != 2'd3) begin
      asm_r[{phase_r, 3'b000} +: 8] <= cur_byte;
    end
  end

  // Code store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  `DM1_ASSERT_HOLDS(a_front_count_bound, 1'b1, code_count_r <= CNT_W'(MAX_CODES))
  `DM1_ASSERT_HOLDS(a_front_sweep_range, state_r == ST_SWEEP, sweep_k_r < n_r)
  `DM1_ASSERT_NEXT(a_front_read_lands, state_r == ST_SWEEP && room_i, rd_valid_r)

endmodule

### rtl/core/dm1dtc_back.sv
`timescale 1ns / 1ps
// Back part: field decode, fault table match and the registered report port.
`include "dm1_dtc_frame_decoder_assert.svh"
module dm1dtc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dm1dtc_pkg::q_status_t status_i,
  input  dm1dtc_pkg::job_t      job_i,
  output logic                  pop_o,
  output logic                  out_valid,
  output logic [3:0]            out_dtc_index,
  output logic [4:0]            out_error_code,
  output logic [18:0]           out_spn_value,
  output logic [4:0]            out_fmi_value,
  output logic [6:0]            out_occurrence_count,
  output logic                  out_conversion_method,
  output logic [7:0]            out_lamp_status,
  output logic [7:0]            out_flash_lamp_status,
  output logic                  out_last
);

  logic                 valid_r;
  logic [3:0]           idx_r;
  dm1dtc_pkg::fault_t   fault_r;
  dm1dtc_pkg::spn_t     spn_r;
  dm1dtc_pkg::fmi_t     fmi_r;
  logic [6:0]           occ_r;
  logic                 method_r;
  logic [7:0]           lamp_r;
  logic [7:0]           flash_r;
  logic                 last_r;

  dm1dtc_pkg::spn_t     spn;
  dm1dtc_pkg::fmi_t     fmi;

  // The receiver never stalls, so one request leaves each cycle while the queue holds any.
  assign pop_o = status_i.not_empty;

  // Split the raw code: SPN takes the top three bits of byte 2.
  assign spn = {job_i.word[23:21], job_i.word[15:0]};
  assign fmi = job_i.word[20:16];

  // Report strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= status_i.not_empty;
    end
  end

  // Report payload.
  always_ff @(posedge clk) begin
    if (status_i.not_empty) begin
      idx_r    <= job_i.idx;
      fault_r  <= dm1dtc_pkg::lookup_fault(spn, fmi);
      spn_r    <= spn;
      fmi_r    <= fmi;
      occ_r    <= job_i.word[30:24];
      method_r <= job_i.word[31];
      lamp_r   <= job_i.lamp;
      flash_r  <= job_i.flash;
      last_r   <= job_i.last;
    end
  end

  assign out_valid             = valid_r;
  assign out_dtc_index         = idx_r;
  assign out_error_code        = fault_r;
  assign out_spn_value         = spn_r;
  assign out_fmi_value         = fmi_r;
  assign out_occurrence_count  = occ_r;
  assign out_conversion_method = method_r;
  assign out_lamp_status       = lamp_r;
  assign out_flash_lamp_status = flash_r;
  assign out_last              = last_r;

  `DM1_ASSERT_HOLDS(a_back_fault_range, out_valid, out_error_code <= 5'd16)

endmodule

### rtl/core/dm1_dtc_frame_decoder.sv
`timescale 1ns / 1ps
// Top level of the DM1 trouble code frame decoder.
// A single frame goes through the report queue and the output registers; a data
// packet walks its seven bytes one per cycle, and a completed message then sweeps
// the code store one entry per cycle while the queue has room. Reports leave at
// one per cycle while the queue holds any, behind the store read register and the
// report queue. Synchronous reset clears all counters and the front lamp state.
module dm1_dtc_frame_decoder #(
  parameter int unsigned MAX_CODES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  input  logic [7:0]  in_byte6,
  input  logic [7:0]  in_byte7,
  output logic        out_valid,
  output logic [3:0]  out_dtc_index,
  output logic [4:0]  out_error_code,
  output logic [18:0] out_spn_value,
  output logic [4:0]  out_fmi_value,
  output logic [6:0]  out_occurrence_count,
  output logic        out_conversion_method,
  output logic [7:0]  out_lamp_status,
  output logic [7:0]  out_flash_lamp_status,
  output logic        out_last
);

  logic [7:0][7:0]        frame;
  logic                   push;
  logic                   pop;
  dm1dtc_pkg::job_t       job_in;
  dm1dtc_pkg::job_t       job_out;
  dm1dtc_pkg::q_status_t  q_status;

  assign frame = {in_byte7, in_byte6, in_byte5, in_byte4,
                  in_byte3, in_byte2, in_byte1, in_byte0};

  // Frame handling and code store.
  dm1dtc_front #(
    .MAX_CODES (MAX_CODES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .cmd_i   (in_cmd),
    .frame_i (frame),
    .room_i  (q_status.room),
    .push_o  (push),
    .job_o   (job_in)
  );

  // Report request queue.
  dm1dtc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .job_i    (job_in),
    .pop_i    (pop),
    .job_o    (job_out),
    .status_o (q_status)
  );

  // Report decode and output.
  dm1dtc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .status_i              (q_status),
    .job_i                 (job_out),
    .pop_o                 (pop),
    .out_valid             (out_valid),
    .out_dtc_index         (out_dtc_index),
    .out_error_code        (out_error_code),
    .out_spn_value         (out_spn_value),
    .out_fmi_value         (out_fmi_value),
    .out_occurrence_count  (out_occurrence_count),
    .out_conversion_method (out_conversion_method),
    .out_lamp_status       (out_lamp_status),
    .out_flash_lamp_status (out_flash_lamp_status),
    .out_last              (out_last)
  );

endmodule

### sim/tb_dm1_dtc_frame_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DM1 trouble code frame decoder, with its own report predictor.
module tb_dm1_dtc_frame_decoder;

  localparam int unsigned STORE_DEPTH  = 16;
  localparam int unsigned ITEM_TARGET  = 350;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned STREAM_BYTES = 112;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [7:0]  FIRST_SEQ    = 8'd1;
  localparam logic [18:0] FOLD_OFFSET  = 19'd19000;

  // Fault table: SPN and FMI pairs, fault number is the row plus one.
  localparam logic [18:0] FAULT_SPN [16] = '{
    19'd1, 19'd1, 19'd2, 19'd3, 19'd3, 19'd4, 19'd5, 19'd3683,
    19'd3683, 19'd6, 19'd7, 19'd7, 19'd7, 19'd8, 19'd1624, 19'd190
  };
  localparam logic [4:0] FAULT_FMI [16] = '{
    5'd2, 5'd12, 5'd2, 5'd2, 5'd19, 5'd2, 5'd2, 5'd2,
    5'd13, 5'd2, 5'd6, 5'd5, 5'd20, 5'd11, 5'd9, 5'd9
  };

  typedef struct packed {
    logic [3:0]  idx;
    logic [4:0]  fault;
    logic [18:0] spn;
    logic [4:0]  fmi;
    logic [6:0]  occ;
    logic        method;
    logic [7:0]  lamp;
    logic [7:0]  flash;
    logic        last;
  } dtc_report_t;

  // Frame bytes are packed with byte 7 in the top bits.
  typedef struct packed {
    logic [1:0]      cmd;
    logic [7:0][7:0] data;
  } can_frame_t;

  typedef struct packed {
    can_frame_t  frame;
    logic        typed;
    dtc_report_t exp;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = '0;
  logic [7:0]  in_byte0 = '0;
  logic [7:0]  in_byte1 = '0;
  logic [7:0]  in_byte2 = '0;
  logic [7:0]  in_byte3 = '0;
  logic [7:0]  in_byte4 = '0;
  logic [7:0]  in_byte5 = '0;
  logic [7:0]  in_byte6 = '0;
  logic [7:0]  in_byte7 = '0;
  logic        out_valid;
  logic [3:0]  out_dtc_index;
  logic [4:0]  out_error_code;
  logic [18:0] out_spn_value;
  logic [4:0]  out_fmi_value;
  logic [6:0]  out_occurrence_count;
  logic        out_conversion_method;
  logic [7:0]  out_lamp_status;
  logic [7:0]  out_flash_lamp_status;
  logic        out_last;

  // Predictor state of the decoder.
  logic [31:0] code_mem [STORE_DEPTH];
  logic [4:0]  codes_held = '0;
  logic [1:0]  code_phase = '0;
  logic [15:0] data_bytes_seen = '0;
  logic [15:0] data_bytes_total = '0;
  logic [7:0]  lamp_state = '0;
  logic [7:0]  flash_state = '0;

  dtc_report_t   report_q [$];
  directed_row_t directed_rows [$];
  int            errors = 0;
  int            frames_sent = 0;
  bit            idle_on = 1'b1;

  dm1_dtc_frame_decoder #(
    .MAX_CODES(STORE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_byte0(in_byte0),
    .in_byte1(in_byte1),
    .in_byte2(in_byte2),
    .in_byte3(in_byte3),
    .in_byte4(in_byte4),
    .in_byte5(in_byte5),
    .in_byte6(in_byte6),
    .in_byte7(in_byte7),
    .out_valid(out_valid),
    .out_dtc_index(out_dtc_index),
    .out_error_code(out_error_code),
    .out_spn_value(out_spn_value),
    .out_fmi_value(out_fmi_value),
    .out_occurrence_count(out_occurrence_count),
    .out_conversion_method(out_conversion_method),
    .out_lamp_status(out_lamp_status),
    .out_flash_lamp_status(out_flash_lamp_status),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  function automatic dtc_report_t make_report(logic [3:0] idx, logic [4:0] fault,
                                              logic [18:0] spn, logic [4:0] fmi,
                                              logic [6:0] occ, logic method,
                                              logic [7:0] lamp, logic [7:0] flash,
                                              logic last);
    dtc_report_t r;
    r.idx    = idx;
    r.fault  = fault;
    r.spn    = spn;
    r.fmi    = fmi;
    r.occ    = occ;
    r.method = method;
    r.lamp   = lamp;
    r.flash  = flash;
    r.last   = last;
    return r;
  endfunction

  // First table row that matches, after SPNs above the offset are folded down.
  function automatic logic [4:0] match_fault(logic [18:0] spn, logic [4:0] fmi);
    logic [18:0] key;
    logic [4:0]  hit;
    key = (spn > FOLD_OFFSET) ? spn - FOLD_OFFSET : spn;
    hit = '0;
    for (int k = 0; k < 16; k++) begin
      if (hit == '0 && FAULT_SPN[k] == key && FAULT_FMI[k] == fmi) begin
        hit = 5'(k + 1);
      end
    end
    return hit;
  endfunction

  // Bytes arriving with the store full are dropped.
  task automatic store_code_byte(input logic [7:0] b);
    if (codes_held < STORE_DEPTH) begin
      code_mem[codes_held][8 * code_phase +: 8] = b;
      code_phase = code_phase + 2'd1;
      if (code_phase == 2'd0) begin
        codes_held = codes_held + 5'd1;
      end
    end
  endtask

  task automatic queue_report(input int idx, input bit last);
    logic [31:0] w;
    logic [18:0] spn;
    w   = code_mem[idx];
    spn = {w[23:21], w[15:0]};
    report_q.push_back(make_report(4'(idx), match_fault(spn, w[20:16]), spn, w[20:16],
                                   w[30:24], w[31], lamp_state, flash_state, last));
  endtask

  // Updates the predictor for one accepted request and queues its reports.
  task automatic predict_frame(input can_frame_t f);
    int n;
    bit done;
    case (f.cmd)
      dm1dtc_pkg::CMD_SINGLE: begin
        lamp_state       = f.data[0];
        codes_held       = '0;
        code_phase       = '0;
        data_bytes_total = 16'd6;
        for (int i = 2; i <= 5; i++) begin
          store_code_byte(f.data[i]);
        end
        queue_report(0, 1'b1);
      end
      dm1dtc_pkg::CMD_ANNOUNCE: begin
        data_bytes_total = {f.data[2], f.data[1]};
        data_bytes_seen  = '0;
        codes_held       = '0;
        code_phase       = '0;
      end
      dm1dtc_pkg::CMD_DATA: begin
        done = 1'b0;
        for (int i = 1; i < 8 && !done; i++) begin
          if (f.data[0] == FIRST_SEQ && i == 1) begin
            lamp_state = f.data[i];
          end else if (f.data[0] == FIRST_SEQ && i == 2) begin
            flash_state = f.data[i];
          end else begin
            store_code_byte(f.data[i]);
          end
          data_bytes_seen = data_bytes_seen + 16'd1;
          // Count reached: report every complete code, drop the rest of the frame.
          if (data_bytes_seen == data_bytes_total) begin
            n = (codes_held > dm1dtc_pkg::REPORT_LIMIT) ? dm1dtc_pkg::REPORT_LIMIT
                                                         : codes_held;
            for (int k = 0; k < n; k++) begin
              queue_report(k, k + 1 == n);
            end
            data_bytes_seen = '0;
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic can_frame_t random_frame();
    can_frame_t f;
    f.cmd  = 2'($urandom);
    f.data = {$urandom, $urandom};
    return f;
  endfunction

  // Half the codes are random words, half hit a table row, folded or not.
  function automatic logic [31:0] make_code();
    logic [18:0] spn;
    int k;
    if ($urandom_range(0, 1) == 0) begin
      return $urandom;
    end
    k   = $urandom_range(0, 15);
    spn = FAULT_SPN[k];
    if ($urandom_range(0, 1) == 1) begin
      spn = spn + FOLD_OFFSET;
    end
    return {1'($urandom), 7'($urandom), spn[18:16], FAULT_FMI[k], spn[15:0]};
  endfunction

  // Mostly back-to-back, some short gaps and a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic put_frame(input can_frame_t f);
    in_cmd   <= f.cmd;
    in_byte0 <= f.data[0];
    in_byte1 <= f.data[1];
    in_byte2 <= f.data[2];
    in_byte3 <= f.data[3];
    in_byte4 <= f.data[4];
    in_byte5 <= f.data[5];
    in_byte6 <= f.data[6];
    in_byte7 <= f.data[7];
  endtask

  // Presents one request, waits for it to be taken, then predicts it.
  task automatic send_frame(input can_frame_t f);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      put_frame(random_frame());
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    put_frame(f);
    do @(posedge clk); while (busy !== 1'b0);
    predict_frame(f);
    if (f.cmd != CMD_UNUSED) begin
      frames_sent++;
    end
  endtask

  // One multi-packet message: announcement, then numbered data packets.
  task automatic send_message();
    logic [7:0]  stream [STREAM_BYTES];
    logic [31:0] code;
    logic [15:0] total;
    can_frame_t  f;
    int          r;
    int          packets;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      total = 16'($urandom_range(1, 40));
    end else if (r < 85) begin
      total = 16'($urandom_range(41, 90));
    end else begin
      total = 16'($urandom);
    end
    packets = (total + 6) / 7;
    if (packets > STREAM_BYTES / 7) begin
      packets = $urandom_range(0, 3);
    end
    // Now and then the message is cut short.
    if ($urandom_range(0, 9) == 0) begin
      packets = $urandom_range(0, packets);
    end
    for (int j = 0; j < STREAM_BYTES; j++) begin
      stream[j] = 8'($urandom);
    end
    // Lamp and flash bytes lead, then four-byte codes.
    for (int s = 2; s + 4 <= STREAM_BYTES; s += 4) begin
      code = make_code();
      for (int m = 0; m < 4; m++) begin
        stream[s + m] = code[8 * m +: 8];
      end
    end
    f         = random_frame();
    f.cmd     = dm1dtc_pkg::CMD_ANNOUNCE;
    f.data[1] = total[7:0];
    f.data[2] = total[15:8];
    send_frame(f);
    for (int k = 0; k < packets; k++) begin
      f.cmd     = dm1dtc_pkg::CMD_DATA;
      f.data[0] = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'(k + 1);
      for (int j = 1; j < 8; j++) begin
        f.data[j] = stream[7 * k + j - 1];
      end
      send_frame(f);
    end
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [63:0] bytes, input bit typed,
                         input dtc_report_t exp);
    directed_row_t row;
    row.frame.cmd  = cmd;
    row.frame.data = bytes;
    row.typed      = typed;
    row.exp        = exp;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Each report strobe is checked against the oldest expectation.
  always @(posedge clk) begin : report_check
    dtc_report_t got;
    dtc_report_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = make_report(out_dtc_index, out_error_code, out_spn_value, out_fmi_value,
                        out_occurrence_count, out_conversion_method, out_lamp_status,
                        out_flash_lamp_status, out_last);
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, got %p", $time, got);
      end else begin
        want = report_q.pop_front();
        check_field("dtc_index", want.idx, got.idx);
        check_field("error_code", want.fault, got.fault);
        check_field("spn_value", want.spn, got.spn);
        check_field("fmi_value", want.fmi, got.fmi);
        check_field("occurrence_count", want.occ, got.occ);
        check_field("conversion_method", want.method, got.method);
        check_field("lamp_status", want.lamp, got.lamp);
        check_field("flash_lamp_status", want.flash, got.flash);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("** dm1_dtc_frame_decoder: FAILED **");
    $finish;
  end

  initial begin
    can_frame_t  f;
    logic [63:0] bytes;
    int          r;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      code_mem[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single frames with reports read straight off the byte layout.
    add_row(dm1dtc_pkg::CMD_SINGLE, 64'h0000_0002_0001_AA55, 1'b1,
            make_report(4'd0, 5'd1, 19'd1, 5'd2, 7'd0, 1'b0, 8'h55, 8'h00, 1'b1));
    add_row(dm1dtc_pkg::CMD_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            make_report(4'd0, 5'd0, 19'h7FFFF, 5'd31, 7'd127, 1'b1, 8'hFF, 8'h00, 1'b1));
    add_row(dm1dtc_pkg::CMD_SINGLE, 64'h0000_0000_0000_0000, 1'b1,
            make_report(4'd0, 5'd0, 19'd0, 5'd0, 7'd0, 1'b0, 8'h00, 8'h00, 1'b1));
    // An SPN of exactly the offset is not folded down.
    add_row(dm1dtc_pkg::CMD_SINGLE, 64'h0000_8102_4A38_000F, 1'b1,
            make_report(4'd0, 5'd0, 19'd19000, 5'd2, 7'd1, 1'b1, 8'h0F, 8'h00, 1'b1));
    add_row(dm1dtc_pkg::CMD_SINGLE, 64'h0000_7F02_4A39_00F0, 1'b1,
            make_report(4'd0, 5'd1, 19'd19001, 5'd2, 7'd127, 1'b0, 8'hF0, 8'h00, 1'b1));
    add_row(dm1dtc_pkg::CMD_SINGLE, 64'h0000_0309_00BE_00C3, 1'b1,
            make_report(4'd0, 5'd16, 19'd190, 5'd9, 7'd3, 1'b0, 8'hC3, 8'h00, 1'b1));
    // The unused frame kind is ignored.
    add_row(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
    // A zero byte total is not reached by one packet.
    add_row(dm1dtc_pkg::CMD_ANNOUNCE, 64'h0000_0000_0000_0000, 1'b0, '0);
    add_row(dm1dtc_pkg::CMD_DATA, 64'h1122_3344_5566_7701, 1'b0, '0);
    // Eleven bytes: two whole codes, a partial one, and a dropped frame tail.
    add_row(dm1dtc_pkg::CMD_ANNOUNCE, 64'h00FE_CA00_0000_0BFF, 1'b0, '0);
    add_row(dm1dtc_pkg::CMD_DATA, 64'h0105_0D0E_6382_4401, 1'b0, '0);
    add_row(dm1dtc_pkg::CMD_DATA, 64'hEEDD_CC99_8002_0002, 1'b0, '0);
    // Seventy-five bytes carry eighteen codes: the store fills at sixteen.
    add_row(dm1dtc_pkg::CMD_ANNOUNCE, 64'h0000_0000_0000_4B00, 1'b0, '0);
    for (int seq = 1; seq <= 11; seq++) begin
      bytes[7:0] = 8'(seq);
      for (int j = 1; j < 8; j++) begin
        bytes[8 * j +: 8] = 8'(seq * 37 + j * 11);
      end
      add_row(dm1dtc_pkg::CMD_DATA, bytes, 1'b0, '0);
    end

    foreach (directed_rows[i]) begin
      send_frame(directed_rows[i].frame);
      if (directed_rows[i].typed) begin
        report_q[report_q.size() - 1] = directed_rows[i].exp;
      end
    end

    // Random part: mostly whole messages, with single frames and noise between.
    while (frames_sent < ITEM_TARGET) begin
      idle_on = ((frames_sent / 40) % 4) != 3;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_message();
      end else if (r < 80) begin
        f     = random_frame();
        f.cmd = dm1dtc_pkg::CMD_SINGLE;
        {f.data[5], f.data[4], f.data[3], f.data[2]} = make_code();
        send_frame(f);
      end else if (r < 88) begin
        f     = random_frame();
        f.cmd = CMD_UNUSED;
        send_frame(f);
      end else if (r < 95) begin
        f     = random_frame();
        f.cmd = dm1dtc_pkg::CMD_DATA;
        send_frame(f);
      end else begin
        f     = random_frame();
        f.cmd = dm1dtc_pkg::CMD_ANNOUNCE;
        send_frame(f);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** dm1_dtc_frame_decoder: PASSED **");
    end else begin
      $display("** dm1_dtc_frame_decoder: FAILED **");
    end
    $finish;
  end

endmodule
